FILE: design/rotate_nearest_source_address_unit_defines.svh
// Assertion macros shared by the rotation source address unit.
`ifndef ROTATE_NEAREST_SOURCE_ADDRESS_UNIT_DEFINES_SVH
`define ROTATE_NEAREST_SOURCE_ADDRESS_UNIT_DEFINES_SVH

// Checks that a condition implies a consequence in the same cycle.
`define RNSA_ASSERT_NOW(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("rnsa assertion failed in same cycle");

// Checks that a condition implies a consequence in the next cycle.
`define RNSA_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("rnsa assertion failed one cycle later");

`endif

FILE: design/rnsa_pkg.sv
// Shared constants, types and the sine and cosine tables of the rotation unit.
package rnsa_pkg;

   localparam int MAX_DIM     = 1024;
   localparam int FRAC_BITS   = 14;
   localparam int COORD_W     = 10;
   localparam int DIM_W       = 11;
   localparam int ANGLE_W     = 9;
   localparam int ANGLE_COUNT = 360;
   localparam int TRIG_W      = FRAC_BITS + 2;
   localparam int DELTA_W     = COORD_W + 1;
   localparam int PROD_W      = DELTA_W + TRIG_W;
   localparam int SUM_W       = PROD_W + 1;
   localparam int INT_W       = SUM_W - FRAC_BITS;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ANGLE_DEG    = 2'd2;

   localparam logic [DIM_W-1:0]   RESET_WIDTH  = 11'd512;
   localparam logic [DIM_W-1:0]   RESET_HEIGHT = 11'd512;
   localparam logic [ANGLE_W-1:0] RESET_ANGLE  = 9'd0;
   localparam logic [ANGLE_W-1:0] ANGLE_WRAP   = 9'd360;

   localparam logic [63:0] PI_Q32  = 64'h3_243F_6A88;
   localparam logic [63:0] Q30_ONE = 64'h4000_0000;

   typedef logic [ANGLE_COUNT-1:0][TRIG_W-1:0] trig_table_type;

   typedef struct packed {
      logic [DIM_W-1:0]         image_width;
      logic [DIM_W-1:0]         image_height;
      logic signed [TRIG_W-1:0] cos_val;
      logic signed [TRIG_W-1:0] sin_val;
   } cfg_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] px;
      logic signed [SUM_W-1:0] py;
   } rot_word_type;

   // Sine of k degrees, k in 0..90, in Q30 by a nine-term Taylor series.
   function automatic logic [63:0] quarter_sin_q30(input int unsigned k);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic [63:0]        prod;
      logic signed [63:0] sum;
      int                 n;
      x    = (((64'(k) * PI_Q32) / 180) + 64'd2) >> 2;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      for (n = 1; n <= 8; n++) begin
         prod = (term * x2) >> 30;
         case (n)
            1:       term = prod / 64'd6;
            2:       term = prod / 64'd20;
            3:       term = prod / 64'd42;
            4:       term = prod / 64'd72;
            5:       term = prod / 64'd110;
            6:       term = prod / 64'd156;
            7:       term = prod / 64'd210;
            default: term = prod / 64'd272;
         endcase
         if (n % 2 == 1) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      if (sum > $signed(Q30_ONE)) begin
         sum = $signed(Q30_ONE);
      end
      return $unsigned(sum);
   endfunction

   function automatic trig_table_type build_sin_table();
      trig_table_type           tab;
      logic signed [TRIG_W-1:0] quarter [91];
      logic [63:0]              v;
      logic signed [TRIG_W-1:0] mag;
      int                       k;
      int                       q;
      int                       r;
      for (k = 0; k <= 90; k++) begin
         v = quarter_sin_q30(k);
         v = (v + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
         quarter[k] = TRIG_W'(v);
      end
      for (k = 0; k < ANGLE_COUNT; k++) begin
         q   = k / 90;
         r   = k % 90;
         mag = (q % 2 == 1) ? quarter[90 - r] : quarter[r];
         tab[k] = (q >= 2) ? -mag : mag;
      end
      return tab;
   endfunction

   function automatic trig_table_type build_cos_table();
      trig_table_type s;
      trig_table_type c;
      int             k;
      s = build_sin_table();
      for (k = 0; k < ANGLE_COUNT; k++) begin
         c[k] = s[(k + 90) % ANGLE_COUNT];
      end
      return c;
   endfunction

   localparam trig_table_type SIN_TABLE = build_sin_table();
   localparam trig_table_type COS_TABLE = build_cos_table();

endpackage

FILE: design/rnsa_csr.sv
// Configuration registers and the registered sine and cosine lookup.
module rnsa_csr import rnsa_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]       csr_write_data,
   output cfg_type                cfg
);

   logic [DIM_W-1:0]         width_ff;
   logic [DIM_W-1:0]         height_ff;
   logic [ANGLE_W-1:0]       angle_ff;
   logic signed [TRIG_W-1:0] cos_ff;
   logic signed [TRIG_W-1:0] sin_ff;
   logic [ANGLE_W-1:0]       angle_idx;
   logic signed [TRIG_W-1:0] cos_in;
   logic signed [TRIG_W-1:0] sin_in;

   // Angles from 360 up wrap once; the register cannot reach 720.
   assign angle_idx = (angle_ff >= ANGLE_WRAP) ? angle_ff - ANGLE_WRAP : angle_ff;
   assign cos_in    = $signed(COS_TABLE[angle_idx]);
   assign sin_in    = $signed(SIN_TABLE[angle_idx]);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
         angle_ff  <= RESET_ANGLE;
         cos_ff    <= $signed(COS_TABLE[0]);
         sin_ff    <= $signed(SIN_TABLE[0]);
      end else begin
         cos_ff <= cos_in;
         sin_ff <= sin_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:  width_ff  <= csr_write_data;
               CSR_IMAGE_HEIGHT: height_ff <= csr_write_data;
               CSR_ANGLE_DEG:    angle_ff  <= csr_write_data[ANGLE_W-1:0];
               default: ;
            endcase
         end
      end
   end

   assign cfg.image_width  = width_ff;
   assign cfg.image_height = height_ff;
   assign cfg.cos_val      = cos_ff;
   assign cfg.sin_val      = sin_ff;

endmodule

FILE: design/rnsa_rotate.sv
// Three-stage rotation datapath: center offsets, products, fixed-point sums.
module rnsa_rotate import rnsa_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [COORD_W-1:0] in_col,
   input  logic [COORD_W-1:0] in_row,
   output logic               out_valid,
   input  logic               out_ready,
   output rot_word_type       out_word
);

   localparam logic [FRAC_BITS-1:0] FRAC_HALF = FRAC_BITS'(1 << (FRAC_BITS - 1));

   logic [COORD_W-1:0]        cx;
   logic [COORD_W-1:0]        cy;
   logic signed [SUM_W-1:0]   cx_fix;
   logic signed [SUM_W-1:0]   cy_fix;

   logic                      v1_ff, v2_ff, v3_ff;
   logic                      rdy1, rdy2, rdy3;

   logic signed [DELTA_W-1:0] dx_ff, dx_in;
   logic signed [DELTA_W-1:0] dy_ff, dy_in;
   logic signed [PROD_W-1:0]  xc_ff, xc_in;
   logic signed [PROD_W-1:0]  ys_ff, ys_in;
   logic signed [PROD_W-1:0]  xs_ff, xs_in;
   logic signed [PROD_W-1:0]  yc_ff, yc_in;
   logic signed [SUM_W-1:0]   px_ff, px_in;
   logic signed [SUM_W-1:0]   py_ff, py_in;

   assign cx     = cfg.image_width[DIM_W-1:1];
   assign cy     = cfg.image_height[DIM_W-1:1];
   // Center plus one half, packed as integer and fraction fields.
   assign cx_fix = $signed(SUM_W'({cx, FRAC_HALF}));
   assign cy_fix = $signed(SUM_W'({cy, FRAC_HALF}));

   assign rdy3     = !v3_ff || out_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   assign dx_in = $signed({1'b0, in_col}) - $signed({1'b0, cx});
   assign dy_in = $signed({1'b0, in_row}) - $signed({1'b0, cy});

   assign xc_in = dx_ff * cfg.cos_val;
   assign ys_in = dy_ff * cfg.sin_val;
   assign xs_in = dx_ff * cfg.sin_val;
   assign yc_in = dy_ff * cfg.cos_val;

   assign px_in = SUM_W'(xc_ff) + SUM_W'(ys_ff) + cx_fix;
   assign py_in = SUM_W'(yc_ff) - SUM_W'(xs_ff) + cy_fix;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && in_valid) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
      end
      if (rdy2 && v1_ff) begin
         xc_ff <= xc_in;
         ys_ff <= ys_in;
         xs_ff <= xs_in;
         yc_ff <= yc_in;
      end
      if (rdy3 && v2_ff) begin
         px_ff <= px_in;
         py_ff <= py_in;
      end
   end

   assign out_valid   = v3_ff;
   assign out_word.px = px_ff;
   assign out_word.py = py_ff;

endmodule

FILE: design/rnsa_bound.sv
// Output stage: truncation toward zero, bounds check and the result register.
module rnsa_bound import rnsa_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  rot_word_type       in_word,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [COORD_W-1:0] rsp_src_col,
   output logic [COORD_W-1:0] rsp_src_row,
   output logic               rsp_inside_res
);

   // Values above this floor truncate to zero or more.
   localparam logic signed [SUM_W-1:0] TRUNC_FLOOR = SUM_W'(1 - (2 ** FRAC_BITS));
   localparam logic [INT_W-1:0]        DIM_LIMIT   = INT_W'(MAX_DIM);

   logic               valid_ff;
   logic [COORD_W-1:0] col_ff, col_in;
   logic [COORD_W-1:0] row_ff, row_in;
   logic               inside_ff, inside_in;
   logic [INT_W-1:0]   xi;
   logic [INT_W-1:0]   yi;
   logic               x_ok;
   logic               y_ok;

   assign in_ready = !valid_ff || !rsp_stall;

   assign xi   = in_word.px[SUM_W-1] ? '0 : in_word.px[SUM_W-1:FRAC_BITS];
   assign yi   = in_word.py[SUM_W-1] ? '0 : in_word.py[SUM_W-1:FRAC_BITS];
   assign x_ok = (in_word.px >= TRUNC_FLOOR) && (xi < INT_W'(cfg.image_width))
                 && (xi < DIM_LIMIT);
   assign y_ok = (in_word.py >= TRUNC_FLOOR) && (yi < INT_W'(cfg.image_height))
                 && (yi < DIM_LIMIT);

   assign inside_in = x_ok && y_ok;
   assign col_in    = inside_in ? xi[COORD_W-1:0] : '0;
   assign row_in    = inside_in ? yi[COORD_W-1:0] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         col_ff    <= col_in;
         row_ff    <= row_in;
         inside_ff <= inside_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_src_col    = col_ff;
   assign rsp_src_row    = row_ff;
   assign rsp_inside_res = inside_ff;

endmodule

FILE: design/rotate_nearest_source_address_unit.sv
// Top level of the nearest-neighbor rotation source address unit.
//
// Each request word carries one destination pixel (req_dest_col, req_dest_row).
// The unit rotates it about the integer image center by the configured whole
// angle and answers with one response word: the source column and row to copy
// and rsp_inside_res, which is 0 (with both coordinates 0) when the source
// falls off the image and the destination keeps its white fill.
// Width, height and angle are written through the csr_ port while the unit
// is idle; register 0 is the width, 1 the height, 2 the angle in degrees.
// The unit takes a new word every cycle while its request side is not stalled.
// A response passes through four register stages: center offsets, four
// multiplies, the two fixed-point sums, then truncation and the bounds check
// into the output register. The multiply stage holds the deepest logic and
// sets the clock period.
// When the receiver stalls, words move up into empty stages and the request
// side stalls only once every stage is full; nothing is lost or repeated.
// Reset clears all stages and loads 512 by 512 pixels at angle 0.
`include "rotate_nearest_source_address_unit_defines.svh"

module rotate_nearest_source_address_unit import rnsa_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [COORD_W-1:0]     req_dest_col,
   input  logic [COORD_W-1:0]     req_dest_row,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [COORD_W-1:0]     rsp_src_col,
   output logic [COORD_W-1:0]     rsp_src_row,
   output logic                   rsp_inside_res,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]       csr_write_data
);

   cfg_type      cfg;
   logic         in_ready;
   logic         rot_valid;
   logic         rot_ready;
   rot_word_type rot_word;

   // Configuration registers; sine and cosine are looked up in the cycle after
   // the angle register changes, which an idle unit always has time for.
   rnsa_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   rnsa_rotate u_rotate (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_ready  (in_ready),
      .in_col    (req_dest_col),
      .in_row    (req_dest_row),
      .out_valid (rot_valid),
      .out_ready (rot_ready),
      .out_word  (rot_word)
   );

   rnsa_bound u_bound (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .in_valid       (rot_valid),
      .in_ready       (rot_ready),
      .in_word        (rot_word),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_src_col    (rsp_src_col),
      .rsp_src_row    (rsp_src_row),
      .rsp_inside_res (rsp_inside_res)
   );

   assign req_stall = !in_ready;

   // An outside result always reads as column and row zero.
   `RNSA_ASSERT_NOW(a_outside_zero, rsp_valid && !rsp_inside_res, rsp_src_col == 0 && rsp_src_row == 0)
   // An inside result lies below the configured width and height.
   `RNSA_ASSERT_NOW(a_inside_col, rsp_valid && rsp_inside_res, 11'(rsp_src_col) < cfg.image_width)
   `RNSA_ASSERT_NOW(a_inside_row, rsp_valid && rsp_inside_res, 11'(rsp_src_row) < cfg.image_height)
   // A word waiting behind a stalled full output stage is still there next cycle.
   `RNSA_ASSERT_NEXT(a_rot_held, rot_valid && !rot_ready, rot_valid)

endmodule
